// ===== hw/rtl/b64_pkg.sv =====
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the character map for the base64 encoder.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // number of real bytes in a group
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // character slot within a group, most significant slice first
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;
    localparam logic [1:0] SLOT_3 = 2'd3;

    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  count;
        logic        last;
    } b64_group_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/b64_front.sv =====
// ----------------------------------------------------------------------------
// b64_front
// Gathers input bytes into groups of up to three and closes a group on its
// third byte or on the last byte of a message.
// ----------------------------------------------------------------------------
module b64_front
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte
    input  logic       s_tlast,     // last_byte
    output logic       push_valid,
    input  logic       push_ready,
    output b64_group_t push_group
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pos_eff;
    logic [1:0]  count;
    logic        accept;
    logic        close;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    // position three never occurs; it restarts a group
    assign pos_eff  = (pos_reg == 2'd3) ? 2'd0 : pos_reg;
    assign count    = pos_eff + 2'd1;
    assign close    = (count == CNT_THREE) || s_tlast;

    always_comb
    begin
        held_next  = held_reg;
        pos_next   = pos_reg;
        push_group = '0;
        case (pos_eff)
            2'd0:    push_group.bits = {s_tdata, 16'h0000};
            2'd1:    push_group.bits = {held_reg[15:8], s_tdata, 8'h00};
            default: push_group.bits = {held_reg, s_tdata};
        endcase
        push_group.count = count;
        push_group.last  = s_tlast;
        if (accept)
        begin
            if (close)
            begin
                held_next = '0;
                pos_next  = 2'd0;
            end
            else
            begin
                held_next = (pos_eff == 2'd0) ? {s_tdata, 8'h00} : {held_reg[15:8], s_tdata};
                pos_next  = count;
            end
        end
    end

    assign push_valid = accept && close;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ===== hw/rtl/b64_queue.sv =====
// ----------------------------------------------------------------------------
// b64_queue
// Short group queue between the byte gatherer and the character emitter.
// ----------------------------------------------------------------------------
module b64_queue
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  b64_group_t push_group,
    output logic       pop_valid,
    input  logic       pop_ready,
    output b64_group_t pop_group
);

    b64_group_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_group  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/b64_back.sv =====
// ----------------------------------------------------------------------------
// b64_back
// Turns one queued group into four characters, one per cycle while m_tready holds, with padding.
// ----------------------------------------------------------------------------
module b64_back
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  b64_group_t pop_group,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_char
    output logic       m_tlast      // last_char
);

    b64_group_t  grp_reg, grp_next;
    logic        busy_reg, busy_next;
    logic [1:0]  slot_reg, slot_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  ochar_reg, ochar_next;
    logic        olast_reg, olast_next;
    logic        load;
    logic        slot_done;
    logic [5:0]  slice;
    logic        pad;

    // output register takes a new character when empty or being drained
    assign load      = busy_reg && (!ovalid_reg || m_tready);
    assign slot_done = load && (slot_reg == SLOT_3);
    assign pop_ready = !busy_reg || slot_done;

    always_comb
    begin
        case (slot_reg)
            SLOT_0:  slice = grp_reg.bits[23:18];
            SLOT_1:  slice = grp_reg.bits[17:12];
            SLOT_2:  slice = grp_reg.bits[11:6];
            default: slice = grp_reg.bits[5:0];
        endcase
        pad = ((slot_reg == SLOT_2) && (grp_reg.count == CNT_ONE)) ||
              ((slot_reg == SLOT_3) && (grp_reg.count != CNT_THREE));
    end

    always_comb
    begin
        grp_next    = grp_reg;
        busy_next   = busy_reg;
        slot_next   = slot_reg;
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;
        if (load)
        begin
            ovalid_next = 1'b1;
            ochar_next  = pad ? PAD_CHAR : b64_char(slice);
            olast_next  = (slot_reg == SLOT_3) && grp_reg.last;
            slot_next   = slot_reg + 2'd1;
            if (slot_reg == SLOT_3)
                busy_next = 1'b0;
        end
        if (pop_valid && pop_ready)
        begin
            grp_next  = pop_group;
            busy_next = 1'b1;
            slot_next = SLOT_0;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ochar_reg;
    assign m_tlast  = olast_reg;

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            slot_reg   <= SLOT_0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            slot_reg   <= slot_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// A closing byte passes the group queue, group register and output register
// before its first character shows. Throughput: 4 characters per group, one
// per cycle from the output register while m_tready holds; bytes that do not
// close a group are taken every cycle while the 2-entry group queue has room.
// Reset: rst_n clears group position, held bytes, queue and output valid.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with '=' padding on the last group of a message.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte
    input  logic       s_tlast,     // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_char
    output logic       m_tlast      // last_char
);

    logic       push_valid;
    logic       push_ready;
    b64_group_t push_group;
    logic       pop_valid;
    logic       pop_ready;
    b64_group_t pop_group;

    b64_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group)
    );

    b64_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_group  (pop_group)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_group (pop_group),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== dv/tb_base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Streams byte messages into the encoder and checks every output character
// and its last marker against a behavioral base64 predictor, under random
// back-pressure and source gaps.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder
    import b64_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_BYTES = 142;
    localparam int TAIL_CYCLES = 20;

    localparam logic [511:0] B64_ALPHABET = {
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "abcdefghijklmnopqrstuvwxyz",
        "0123456789+/"
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_byte_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;     // data_byte
    logic       s_tlast = 1'b0;      // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;             // out_char
    logic       m_tlast;             // last_char

    raw_byte_t  byte_q[$];
    enc_char_t  char_q[$];
    raw_byte_t  drv_next;
    enc_char_t  exp_char;

    // encoder state mirror
    logic [15:0] enc_held = 16'h0000;
    logic [1:0]  enc_pos = 2'd0;

    int src_idle_pct = 19;
    int snk_idle_pct = 61;
    int err_count = 0;
    int idle_cycles = 0;

    base64_stream_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [1:0]  pos;
        logic [1:0]  count;
        logic [23:0] grp;
        enc_char_t   c;
        pos = (enc_pos == CNT_THREE) ? 2'd0 : enc_pos;
        if (pos == 2'd0)
        begin
            enc_held = {b, 8'h00};
            count = CNT_ONE;
        end
        else if (pos == CNT_ONE)
        begin
            enc_held[7:0] = b;
            count = CNT_TWO;
        end
        else
        begin
            count = CNT_THREE;
        end
        if (count != CNT_THREE && !last)
        begin
            enc_pos = count;
        end
        else
        begin
            grp = {enc_held, (count == CNT_THREE) ? b : 8'h00};
            c = '{sextet_char(grp[23:18]), 1'b0};
            char_q.push_back(c);
            c = '{sextet_char(grp[17:12]), 1'b0};
            char_q.push_back(c);
            c = '{(count == CNT_ONE) ? PAD_CHAR : sextet_char(grp[11:6]), 1'b0};
            char_q.push_back(c);
            c = '{(count != CNT_THREE) ? PAD_CHAR : sextet_char(grp[5:0]), last};
            char_q.push_back(c);
            enc_held = 16'h0000;
            enc_pos = 2'd0;
        end
    endtask

    task automatic push_byte(input logic [7:0] d, input logic l);
        raw_byte_t r;
        r = '{d, l};
        byte_q.push_back(r);
    endtask

    task automatic push_random_message(input int len);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (byte_q.size() != 0 || s_tvalid || char_q.size() != 0)
            @(negedge clk);
    endtask

    // source side: hold the word until taken, random gaps between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                drv_next = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_next.data;
                s_tlast  <= drv_next.last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side, prediction, checking and stall watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);

            if (m_tvalid && m_tready)
            begin
                if (char_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("%0t: unexpected word char=%02h last=%0b",
                                 $realtime, m_tdata, m_tlast);
                    err_count++;
                end
                else
                begin
                    exp_char = char_q.pop_front();
                    if (m_tdata !== exp_char.ch || m_tlast !== exp_char.last)
                    begin
                        if (err_count < 10)
                            $display("%0t: char exp %02h got %02h, last exp %0b got %0b",
                                     $realtime, exp_char.ch, m_tdata,
                                     exp_char.last, m_tlast);
                        err_count++;
                    end
                end
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int queued;
        int len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single byte, pairs, full groups of each padding form,
        // all-'+' and all-'/' groups, group followed by a short tail
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFB, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBE, 1'b1);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h6E, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hFE, 1'b1);
        // hold off until every expected char is out
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 19;
                    snk_idle_pct = 61;
                end
                1:
                begin
                    src_idle_pct = 61;
                    snk_idle_pct = 19;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            queued = 0;
            while (queued < PHASE_BYTES)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(10, 40);
                else
                    len = $urandom_range(1, 9);
                push_random_message(len);
                queued += len;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && char_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/b64_pkg.sv
hw/rtl/b64_front.sv
hw/rtl/b64_queue.sv
hw/rtl/b64_back.sv
hw/rtl/base64_stream_encoder.sv
dv/tb_base64_stream_encoder.sv
